/* rtl/uvst_pkg.sv */
// Package for the unique value set table: field widths, codes and transfer structs.
package uvst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 6;
  localparam int CNT_OUT_W    = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e_t;

  typedef struct packed {
    op_e_t                      opcode;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
  } in_item_t;

  typedef struct packed {
    status_e_t                  status;
    logic                       found;
    logic [POS_W-1:0]           slot;
    logic signed [VALUE_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0]       entry_count;
  } out_item_t;

endpackage

/* rtl/uvst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/uvst_ctrl.sv */
// Sequencer: scans the entry RAM, performs insert, swap remove, lookup and read.
module uvst_ctrl #(
  parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uvst_pkg::in_item_t   in_data,
  output logic                 res_vld,
  input  logic                 res_take,
  output uvst_pkg::out_item_t  res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > uvst_pkg::POS_W) ? CW : uvst_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_RD   = 7'b0000100,
    S_RDW  = 7'b0001000,
    S_RMRD = 7'b0010000,
    S_RMWR = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t                              state_r, state_nxt;
  uvst_pkg::op_e_t                     op_r, op_nxt;
  logic [uvst_pkg::VALUE_W-1:0]        val_r, val_nxt;
  logic [uvst_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]                       idx_r, idx_nxt;
  logic                                cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                       cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]                       hit_idx_r, hit_idx_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  uvst_pkg::out_item_t                 res_r, res_nxt;

  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  logic [uvst_pkg::VALUE_W-1:0]        ram_wdata;
  logic [AW-1:0]                       ram_raddr;
  logic [uvst_pkg::VALUE_W-1:0]        ram_rdata;
  logic                                hit;

  uvst_ram #(
    .WIDTH (uvst_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign res_vld  = (state_r == S_FIN);
  assign res      = res_r;
  assign hit      = cmp_vld_r && (ram_rdata == val_r);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(count_r);
    ram_wdata   = val_r;
    ram_raddr   = AW'(idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          val_nxt = in_data.value;
          pos_nxt = in_data.position;
          idx_nxt = '0;
          state_nxt = (in_data.opcode == uvst_pkg::OP_READ) ? S_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        res_nxt.read_value  = '0;
        res_nxt.entry_count = uvst_pkg::CNT_OUT_W'(count_r);
        if (hit) begin
          if (op_r == uvst_pkg::OP_REMOVE) begin
            hit_idx_nxt = cmp_idx_r;
            state_nxt   = S_RMRD;
          end else begin
            res_nxt.status = uvst_pkg::ST_OK;
            res_nxt.found  = 1'b1;
            res_nxt.slot   = uvst_pkg::POS_W'(cmp_idx_r);
            state_nxt      = S_FIN;
          end
        end else if (idx_r < count_r) begin
          ram_raddr   = AW'(idx_r);
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = AW'(idx_r);
        end else begin
          res_nxt.found = 1'b0;
          res_nxt.slot  = '0;
          state_nxt     = S_FIN;
          if (op_r == uvst_pkg::OP_INSERT) begin
            if (count_r < CW'(CAPACITY)) begin
              ram_we              = 1'b1;
              count_nxt           = count_r + 1'b1;
              res_nxt.status      = uvst_pkg::ST_OK;
              res_nxt.slot        = uvst_pkg::POS_W'(count_r);
              res_nxt.entry_count = uvst_pkg::CNT_OUT_W'(count_r + 1'b1);
            end else begin
              res_nxt.status = uvst_pkg::ST_FULL;
            end
          end else begin
            res_nxt.status = uvst_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_RMRD: begin
        ram_raddr = AW'(count_r - 1'b1);
        state_nxt = S_RMWR;
      end
      S_RMWR: begin
        ram_we              = 1'b1;
        ram_waddr           = hit_idx_r;
        ram_wdata           = ram_rdata;
        count_nxt           = count_r - 1'b1;
        res_nxt.status      = uvst_pkg::ST_OK;
        res_nxt.found       = 1'b1;
        res_nxt.slot        = uvst_pkg::POS_W'(hit_idx_r);
        res_nxt.read_value  = '0;
        res_nxt.entry_count = uvst_pkg::CNT_OUT_W'(count_r - 1'b1);
        state_nxt           = S_FIN;
      end
      S_RD: begin
        res_nxt.found       = 1'b0;
        res_nxt.slot        = pos_r;
        res_nxt.read_value  = '0;
        res_nxt.entry_count = uvst_pkg::CNT_OUT_W'(count_r);
        if (XW'(pos_r) < XW'(count_r)) begin
          ram_raddr = AW'(pos_r);
          state_nxt = S_RDW;
        end else begin
          res_nxt.status = uvst_pkg::ST_RANGE;
          state_nxt      = S_FIN;
        end
      end
      S_RDW: begin
        res_nxt.status     = uvst_pkg::ST_OK;
        res_nxt.read_value = ram_rdata;
        state_nxt          = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r     <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_RMWR))
    else $error("RAM write outside insert or remove");

  a_rm_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RMRD |=> state_r == S_RMWR)
    else $error("swap remove sequence broken");

  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> $past(ram_we))
    else $error("count changed without RAM write");

endmodule

/* rtl/unique_value_set_table_top.sv */
// Top level of the unique value set table: sequencer, entry RAM and output register.
//
// The table holds up to CAPACITY unique signed 32-bit values packed in slots
// 0 to count-1 of one RAM. Items are processed one at a time. Insert, remove
// and lookup scan the stored entries one per cycle through the RAM's single
// read port and stop early when the value is found; a remove that hits then
// moves the last entry into the hit slot. A read returns the entry at its
// position, or a range status when the position is out of range. Results go
// through an output register, so the next item is taken while a finished
// result waits for its transfer. Entries need no clearing after reset.
module unique_value_set_table_top #(
  parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uvst_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uvst_pkg::out_item_t  out_data
);

  logic                res_vld;
  logic                res_take;
  uvst_pkg::out_item_t res;
  logic                out_valid_r;
  uvst_pkg::out_item_t out_r;

  uvst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res_vld  (res_vld),
    .res_take (res_take),
    .res      (res)
  );

  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
